// ===== hw/rtl/matrix_keypad_scanner_top_defines.svh =====
// assertion macros for the keypad scanner
// used by matrix_keypad_scanner_top, expects clk_i and rst_ni in scope
`ifndef MATRIX_KEYPAD_SCANNER_TOP_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_TOP_DEFINES_SVH
`ifndef SYNTH
`define MKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MKS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MKS_ASSERT(lbl, prop, msg)
`define MKS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/mks_pkg.sv =====
// types, constants and key decode for the keypad scanner
// no dependencies
package mks_pkg;

  localparam int unsigned RowCountDefault = 4;
  localparam int unsigned ColW    = 4;
  localparam int unsigned CharW   = 7;
  localparam int unsigned TickW   = 16;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [ColW-1:0] COLS_RELEASED = 4'hF;
  localparam logic [TickW-1:0] DEBOUNCE_RESET = 16'd15;
  localparam logic [TickW-1:0] SETTLE_RESET   = 16'd1;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE   = 4'd1;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_SCAN     = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ColW-1:0]  row_drive;
    logic             key_ready;
    logic [CharW-1:0] key_char;
  } mks_res_t;

  // row-major, four positions per row
  localparam logic [CharW-1:0] KEY_TABLE [16] = '{
    7'h2A, 7'h37, 7'h34, 7'h31,
    7'h30, 7'h38, 7'h35, 7'h32,
    7'h23, 7'h39, 7'h36, 7'h33,
    7'h44, 7'h43, 7'h42, 7'h41
  };

  function automatic logic [CharW-1:0] key_decode(logic [1:0] row, logic [ColW-1:0] col);
    logic [1:0] pos;
    logic       hit;
    pos = 2'd0;
    hit = 1'b1;
    case (col)
      4'h7: pos = 2'd0;
      4'hB: pos = 2'd1;
      4'hD: pos = 2'd2;
      4'hE: pos = 2'd3;
      default: hit = 1'b0;
    endcase
    return hit ? KEY_TABLE[{row, pos}] : '0;
  endfunction

endpackage

// ===== hw/rtl/mks_if.sv =====
// request channel interfaces of the keypad scanner
// depends on mks_pkg
interface mks_in_if import mks_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ColW-1:0] column_sample;
  modport source (output valid, output column_sample, input ready);
  modport sink (input valid, input column_sample, output ready);
endinterface

interface mks_out_if import mks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ColW-1:0]  row_drive;
  logic             key_ready;
  logic [CharW-1:0] key_char;
  modport source (output valid, output row_drive, output key_ready, output key_char,
                  input ready);
  modport sink (input valid, input row_drive, input key_ready, input key_char,
                output ready);
endinterface

interface mks_cfg_if import mks_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TickW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mks_core.sv =====
// scan state machine: one step per accepted column sample
// depends on mks_pkg
module mks_core import mks_pkg::*; #(
  parameter int unsigned ROW_COUNT = RowCountDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ColW-1:0]  col_i,
  input  logic [TickW-1:0] debounce_i,
  input  logic [TickW-1:0] settle_i,
  output mks_res_t         res_o
);

  localparam int unsigned RowW = $clog2(ROW_COUNT);
  localparam logic [RowW-1:0] RowLast = RowW'(ROW_COUNT - 1);

  phase_e           phase_q, phase_d;
  logic [TickW-1:0] wait_q, wait_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             held_q, held_d;
  logic             waiting, released;

  assign waiting  = wait_q > TickW'(1);
  assign released = col_i == COLS_RELEASED;

  always_comb begin
    case (phase_q)
      PH_DEBOUNCE: begin
        if (waiting) phase_d = PH_DEBOUNCE;
        else if (released) phase_d = PH_IDLE;
        else phase_d = PH_SCAN;
      end
      PH_SCAN: begin
        if (waiting) phase_d = PH_SCAN;
        else if (!released || row_q == RowLast) phase_d = PH_IDLE;
        else phase_d = PH_SCAN;
      end
      default: begin
        if (!released && !held_q) phase_d = PH_DEBOUNCE;
        else phase_d = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    wait_d            = wait_q;
    row_d             = row_q;
    held_d            = held_q;
    res_o.key_ready   = 1'b0;
    res_o.key_char    = '0;
    case (phase_q)
      PH_DEBOUNCE: begin
        if (waiting) begin
          wait_d = wait_q - TickW'(1);
        end else if (!released) begin
          row_d  = '0;
          wait_d = settle_i;
        end
      end
      PH_SCAN: begin
        if (waiting) begin
          wait_d = wait_q - TickW'(1);
        end else if (!released) begin
          res_o.key_ready = 1'b1;
          res_o.key_char  = key_decode(2'(row_q), col_i);
          held_d          = 1'b1;
        end else if (row_q == RowLast) begin
          res_o.key_ready = 1'b1;
          held_d          = 1'b1;
        end else begin
          row_d  = row_q + RowW'(1);
          wait_d = settle_i;
        end
      end
      default: begin
        if (released) begin
          held_d = 1'b0;
        end else if (!held_q) begin
          wait_d = debounce_i;
        end
      end
    endcase
    res_o.row_drive = (phase_d == PH_SCAN) ? ~(ColW'(1) << row_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wait_q  <= '0;
      row_q   <= '0;
      held_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      row_q   <= row_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== hw/rtl/matrix_keypad_scanner_top.sv =====
// keypad scanner top level: channels, config registers, result register
// depends on mks_pkg, mks_if, mks_core and matrix_keypad_scanner_top_defines.svh
//
// Each accepted column sample gives exactly one result (row drive for the next
// sample, key_ready and key_char), registered into the output register when
// the sample is accepted. A new sample is taken every cycle as long as the
// output register is empty or its result is taken in that same cycle: the scan
// state updates once per sample, so throughput is one sample per clock. Config
// writes are always ready and take effect on the next sample.
`include "matrix_keypad_scanner_top_defines.svh"

module matrix_keypad_scanner_top import mks_pkg::*; #(
  parameter int unsigned ROW_COUNT = RowCountDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  mks_in_if.sink   in_i,
  mks_out_if.source out_o,
  mks_cfg_if.sink  cfg_i
);

  logic [TickW-1:0] debounce_q, settle_q;
  logic             out_valid_q;
  mks_res_t         res_q, res_d;
  logic             step;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign step        = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      settle_q   <= SETTLE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_DEBOUNCE: debounce_q <= cfg_i.data;
        CFG_SETTLE:   settle_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  mks_core #(
    .ROW_COUNT(ROW_COUNT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .col_i      (in_i.column_sample),
    .debounce_i (debounce_q),
    .settle_i   (settle_q),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.row_drive = res_q.row_drive;
  assign out_o.key_ready = res_q.key_ready;
  assign out_o.key_char  = res_q.key_char;

  `MKS_ASSERT(a_char_only_on_ready, out_o.valid && !out_o.key_ready |-> out_o.key_char == '0, "key_char set without key_ready")
  `MKS_ASSERT(a_single_row, out_o.valid && out_o.row_drive != '0 |-> $onehot(~out_o.row_drive), "more than one row driven low")
  `MKS_ASSERT(a_result_after_step, step |=> out_o.valid, "accepted request gave no result")
  `MKS_ASSERT(a_no_stall_when_empty, !out_valid_q |-> in_i.ready, "input stalled with empty output")
  `MKS_ASSERT_RST(a_reset_empty, !rst_ni |-> !out_o.valid, "result valid in reset")

endmodule
